// ----- sv/bbt_pkg.sv -----
package bbt_pkg;

   localparam int unsigned TIME_W    = 31;
   localparam int unsigned VAL_W     = 32;
   localparam int unsigned TSTAR_W   = 52;
   localparam int unsigned RAD_W     = 68;
   localparam int unsigned ROOT_W    = RAD_W / 2;
   localparam int unsigned SQRT_REM_W = ROOT_W + 2;
   localparam int unsigned NUM_W     = 35;
   localparam int unsigned DVD_W     = 52;
   localparam int unsigned CNT_W     = 6;
   localparam int unsigned ADDR_W    = 5;

   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DVD_W - 1);

   localparam logic [ADDR_W-3:0] REG_ACCEL_LIMIT = 3'd0;
   localparam logic [ADDR_W-3:0] REG_START_POS   = 3'd1;
   localparam logic [ADDR_W-3:0] REG_START_VEL   = 3'd2;
   localparam logic [ADDR_W-3:0] REG_TARGET_POS  = 3'd3;
   localparam logic [ADDR_W-3:0] REG_TARGET_VEL  = 3'd4;

   localparam logic [TIME_W-1:0] ACCEL_RESET = 31'd65536;

   typedef struct packed {
      logic [TIME_W-1:0]       accel_limit;
      logic signed [VAL_W-1:0] start_pos;
      logic signed [VAL_W-1:0] start_vel;
      logic signed [VAL_W-1:0] target_pos;
      logic signed [VAL_W-1:0] target_vel;
   } cfg_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] accel;
      logic [TSTAR_W-1:0]      tstar;
      logic [TIME_W-1:0]       total;
   } sol_type;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_PREP = 10'b0000000010,
      ST_MUL0 = 10'b0000000100,
      ST_MUL1 = 10'b0000001000,
      ST_MUL2 = 10'b0000010000,
      ST_SIGN = 10'b0000100000,
      ST_SQRT = 10'b0001000000,
      ST_NUM  = 10'b0010000000,
      ST_DIV0 = 10'b0100000000,
      ST_DIV1 = 10'b1000000000
   } state_type;

endpackage

// ----- sv/bbt_solver.sv -----
module bbt_solver (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  bbt_pkg::cfg_type cfg,
   output logic             busy,
   output bbt_pkg::sol_type sol
);

   bbt_pkg::state_type st_ff, st_in;
   logic [bbt_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic [30:0]        a_ff, a_in;
   logic               dneg_ff, dneg_in;
   logic [31:0]        dmag_ff, dmag_in;
   logic signed [32:0] v0_ff, v0_in, v1_ff, v1_in;
   logic [63:0]        sq0_ff, sq0_in, sq1_ff, sq1_in, ad2_ff, ad2_in;
   logic               sneg_ff, sneg_in;
   logic [bbt_pkg::RAD_W-1:0]      rad_ff, rad_in;
   logic [bbt_pkg::SQRT_REM_W-1:0] srem_ff, srem_in;
   logic [bbt_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [bbt_pkg::NUM_W-1:0]      tsn_ff, tsn_in;
   logic [bbt_pkg::DVD_W-1:0]      dvd_ff, dvd_in;
   logic [31:0]                    drem_ff, drem_in;
   bbt_pkg::sol_type               sol_ff, sol_in;

   // shared multiplier for the three squares/products
   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;

   // prep terms
   logic signed [32:0] disp;
   logic               dneg;

   // sign decision
   logic [65:0] s_sq0, s_sq1, s_ad2, s_two, s_ad4;
   logic        c1, c2, s_neg;

   // square root step
   logic [bbt_pkg::SQRT_REM_W+1:0] sq_sh, sq_trial;

   // numerator terms
   logic signed [35:0] vsum, vdif, n_raw, n_cl, t_raw;

   // divider step
   logic [32:0] dv_sh, dv_div;
   logic [bbt_pkg::DVD_W-1:0] dvd_step;
   logic [31:0] drem_step;

   assign busy = (st_ff != bbt_pkg::ST_IDLE);
   assign sol  = sol_ff;

   assign disp = 33'(cfg.target_pos) - 33'(cfg.start_pos);
   assign dneg = disp[32];

   always_comb begin
      mul_x = v0_ff[32] ? 32'(-v0_ff) : v0_ff[31:0];
      mul_y = mul_x;
      unique case (st_ff)
         bbt_pkg::ST_MUL1: begin
            mul_x = v1_ff[32] ? 32'(-v1_ff) : v1_ff[31:0];
            mul_y = mul_x;
         end
         bbt_pkg::ST_MUL2: begin
            mul_x = {a_ff, 1'b0};
            mul_y = dmag_ff;
         end
         default: ;
      endcase
   end
   assign mul_p = mul_x * mul_y;

   assign s_sq0 = 66'(sq0_ff);
   assign s_sq1 = 66'(sq1_ff);
   assign s_ad2 = 66'(ad2_ff);
   assign c1    = (v1_ff > 0) && ((s_sq0 + s_ad2) < s_sq1);
   assign c2    = (v0_ff > 0) && ((s_sq1 + s_ad2) < s_sq0);
   assign s_neg = c1 | c2;
   assign s_two = (s_sq0 + s_sq1) << 1;
   assign s_ad4 = s_ad2 << 1;

   // two radicand bits per step
   assign sq_sh    = {srem_ff, rad_ff[bbt_pkg::RAD_W-1 -: 2]};
   assign sq_trial = (bbt_pkg::SQRT_REM_W+2)'({root_ff, 2'b01});

   assign vsum  = 36'(v0_ff) + 36'(v1_ff);
   assign vdif  = 36'(v1_ff) - 36'(v0_ff);
   assign n_raw = sneg_ff ? 36'(root_ff) + vsum : 36'(root_ff) - vsum;
   assign n_cl  = n_raw[35] ? 36'sd0 : n_raw;
   assign t_raw = sneg_ff ? n_cl - vdif : n_cl + vdif;

   assign dv_div    = st_ff == bbt_pkg::ST_DIV1 ? {a_ff, 2'b00} >> 1 : {2'b00, a_ff};
   assign dv_sh     = {drem_ff, dvd_ff[bbt_pkg::DVD_W-1]};
   assign dvd_step  = {dvd_ff[bbt_pkg::DVD_W-2:0], dv_sh >= dv_div};
   assign drem_step = dv_sh >= dv_div ? 32'(dv_sh - dv_div) : dv_sh[31:0];

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff + 1'b1;
      a_in    = a_ff;
      dneg_in = dneg_ff;
      dmag_in = dmag_ff;
      v0_in   = v0_ff;
      v1_in   = v1_ff;
      sq0_in  = sq0_ff;
      sq1_in  = sq1_ff;
      ad2_in  = ad2_ff;
      sneg_in = sneg_ff;
      rad_in  = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      tsn_in  = tsn_ff;
      dvd_in  = dvd_ff;
      drem_in = drem_ff;
      sol_in  = sol_ff;
      unique case (st_ff)
         bbt_pkg::ST_IDLE: ;
         bbt_pkg::ST_PREP: begin
            a_in    = cfg.accel_limit == '0 ? 31'd1 : cfg.accel_limit;
            dneg_in = dneg;
            dmag_in = dneg ? 32'(-disp) : disp[31:0];
            v0_in   = dneg ? -33'(cfg.start_vel)  : 33'(cfg.start_vel);
            v1_in   = dneg ? -33'(cfg.target_vel) : 33'(cfg.target_vel);
            st_in   = bbt_pkg::ST_MUL0;
         end
         bbt_pkg::ST_MUL0: begin
            sq0_in = mul_p;
            st_in  = bbt_pkg::ST_MUL1;
         end
         bbt_pkg::ST_MUL1: begin
            sq1_in = mul_p;
            st_in  = bbt_pkg::ST_MUL2;
         end
         bbt_pkg::ST_MUL2: begin
            ad2_in = mul_p;
            st_in  = bbt_pkg::ST_SIGN;
         end
         bbt_pkg::ST_SIGN: begin
            sneg_in = s_neg;
            if (!s_neg) begin
               rad_in = bbt_pkg::RAD_W'(s_two + s_ad4);
            end else if (s_two < s_ad4) begin
               rad_in = '0;
            end else begin
               rad_in = bbt_pkg::RAD_W'(s_two - s_ad4);
            end
            srem_in = '0;
            root_in = '0;
            cnt_in  = '0;
            st_in   = bbt_pkg::ST_SQRT;
         end
         bbt_pkg::ST_SQRT: begin
            rad_in = rad_ff << 2;
            if (sq_sh >= sq_trial) begin
               srem_in = bbt_pkg::SQRT_REM_W'(sq_sh - sq_trial);
               root_in = {root_ff[bbt_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = sq_sh[bbt_pkg::SQRT_REM_W-1:0];
               root_in = {root_ff[bbt_pkg::ROOT_W-2:0], 1'b0};
            end
            if (cnt_ff == bbt_pkg::SQRT_LAST) st_in = bbt_pkg::ST_NUM;
         end
         bbt_pkg::ST_NUM: begin
            tsn_in  = t_raw[35] ? '0 : t_raw[bbt_pkg::NUM_W-1:0];
            dvd_in  = bbt_pkg::DVD_W'({n_cl[bbt_pkg::NUM_W-1:0], 16'h0000});
            drem_in = '0;
            cnt_in  = '0;
            st_in   = bbt_pkg::ST_DIV0;
         end
         bbt_pkg::ST_DIV0: begin
            dvd_in  = dvd_step;
            drem_in = drem_step;
            if (cnt_ff == bbt_pkg::DIV_LAST) begin
               sol_in.total = dvd_step[bbt_pkg::DVD_W-1:31] != '0 ? '1 : dvd_step[30:0];
               dvd_in  = bbt_pkg::DVD_W'({tsn_ff, 16'h0000});
               drem_in = '0;
               cnt_in  = '0;
               st_in   = bbt_pkg::ST_DIV1;
            end
         end
         bbt_pkg::ST_DIV1: begin
            dvd_in  = dvd_step;
            drem_in = drem_step;
            if (cnt_ff == bbt_pkg::DIV_LAST) begin
               sol_in.tstar = dvd_step;
               sol_in.accel = (dneg_ff ^ sneg_ff) ? -32'(a_ff) : 32'(a_ff);
               st_in = bbt_pkg::ST_IDLE;
            end
         end
         default: st_in = bbt_pkg::ST_IDLE;
      endcase
      if (start) st_in = bbt_pkg::ST_PREP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= bbt_pkg::ST_PREP;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
      a_ff    <= a_in;
      dneg_ff <= dneg_in;
      dmag_ff <= dmag_in;
      v0_ff   <= v0_in;
      v1_ff   <= v1_in;
      sq0_ff  <= sq0_in;
      sq1_ff  <= sq1_in;
      ad2_ff  <= ad2_in;
      sneg_ff <= sneg_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      tsn_ff  <= tsn_in;
      dvd_ff  <= dvd_in;
      drem_ff <= drem_in;
      sol_ff  <= sol_in;
   end

endmodule

// ----- sv/bang_bang_trajectory_eval.sv -----
// One req word accepted per cycle while req_stall is low; results leave on rsp_valid.
// After reset and after every register write a serial solver (square root, then
// two restoring divides) runs; req_stall is high while it is busy.
// Reset is synchronous, active high: registers return to their reset values
// and the pipeline empties.
module bang_bang_trajectory_eval (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [30:0]         req_eval_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_pos_out,
   output logic signed [31:0]  rsp_vel_out,
   output logic signed [31:0]  rsp_accel_out,
   output logic [30:0]         rsp_total_time,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   bbt_pkg::cfg_type cfg_ff, cfg_in;
   bbt_pkg::sol_type sol;
   logic             busy;
   logic             wr;
   logic             en;
   logic [7:1]       vld_ff, vld_in;

   logic signed [31:0] a;

   // stage 1
   logic [30:0] t1_ff, t2_ff;
   logic        p1_ff;
   // stage 2
   logic [61:0]        tsq_ff, t2sq_ff;
   logic signed [62:0] svt_ff;
   logic signed [32:0] r_ff;
   logic               p2_ff;
   // stage 3
   logic signed [63:0] q_ff;
   logic signed [64:0] ar_ff;
   logic signed [62:0] svt3_ff;
   logic               p3_ff;
   // stage 4
   logic signed [64:0] pl_ff;
   logic signed [63:0] ph_ff;
   logic signed [65:0] vv_ff;
   logic signed [80:0] xb_ff;
   logic               p4_ff;
   // stage 5
   logic signed [97:0] aq_ff;
   logic signed [80:0] xb5_ff;
   logic signed [65:0] vv5_ff;
   logic               p5_ff;
   // stage 6
   logic signed [99:0] x_ff;
   logic signed [65:0] vv6_ff;
   logic               p6_ff;
   // output
   logic signed [31:0] pos_ff, vel_ff, acc_ff;
   logic [30:0]        tot_ff;

   logic               phase1;
   logic signed [66:0] xs;
   logic signed [49:0] vs;

   bbt_solver u_solver (
      .clock (clock),
      .reset (reset),
      .start (wr),
      .cfg   (cfg_ff),
      .busy  (busy),
      .sol   (sol)
   );

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_paddr[4:2])
            bbt_pkg::REG_ACCEL_LIMIT: cfg_in.accel_limit = csr_pwdata[30:0];
            bbt_pkg::REG_START_POS:   cfg_in.start_pos   = csr_pwdata;
            bbt_pkg::REG_START_VEL:   cfg_in.start_vel   = csr_pwdata;
            bbt_pkg::REG_TARGET_POS:  cfg_in.target_pos  = csr_pwdata;
            bbt_pkg::REG_TARGET_VEL:  cfg_in.target_vel  = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         bbt_pkg::REG_ACCEL_LIMIT: csr_prdata = {1'b0, cfg_ff.accel_limit};
         bbt_pkg::REG_START_POS:   csr_prdata = cfg_ff.start_pos;
         bbt_pkg::REG_START_VEL:   csr_prdata = cfg_ff.start_vel;
         bbt_pkg::REG_TARGET_POS:  csr_prdata = cfg_ff.target_pos;
         bbt_pkg::REG_TARGET_VEL:  csr_prdata = cfg_ff.target_vel;
         default:                  csr_prdata = '0;
      endcase
   end

   assign a         = sol.accel;
   assign en        = !(vld_ff[7] && rsp_stall);
   assign req_stall = busy || !en;
   assign vld_in    = {vld_ff[6:1], req_valid && !busy};
   assign phase1    = 52'(req_eval_time) < sol.tstar;

   // floor shifts of the exact sums
   assign xs = 67'(x_ff >>> 33);
   assign vs = 50'(vv6_ff >>> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_limit <= bbt_pkg::ACCEL_RESET;
         cfg_ff.start_pos   <= '0;
         cfg_ff.start_vel   <= '0;
         cfg_ff.target_pos  <= '0;
         cfg_ff.target_vel  <= '0;
         vld_ff             <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (en) vld_ff <= vld_in;
      end
      if (en) begin
         // stage 1: phase select; t2 only meaningful in phase two
         t1_ff <= req_eval_time;
         p1_ff <= phase1;
         t2_ff <= req_eval_time - sol.tstar[30:0];
         // stage 2: t^2, t2^2 and r; in phase two r = 2*t* - t, and stage 3 forms q = t^2 - 2*t2^2
         tsq_ff  <= t1_ff * t1_ff;
         t2sq_ff <= p1_ff ? 62'd0 : t2_ff * t2_ff;
         svt_ff  <= 63'(cfg_ff.start_vel) * 63'($signed({1'b0, t1_ff}));
         r_ff    <= p1_ff ? 33'($signed({1'b0, t1_ff}))
                          : $signed({1'b0, sol.tstar[30:0], 1'b0}) - 33'($signed({1'b0, t1_ff}));
         p2_ff   <= p1_ff;
         // stage 3
         q_ff    <= $signed(64'(tsq_ff) - 64'({t2sq_ff, 1'b0}));
         ar_ff   <= 65'(a) * 65'(r_ff);
         svt3_ff <= svt_ff;
         p3_ff   <= p2_ff;
         // stage 4: a*q split into two 32-bit partial products
         pl_ff <= 65'(a) * 65'($signed({1'b0, q_ff[31:0]}));
         ph_ff <= 64'(a) * 64'($signed(q_ff[63:32]));
         vv_ff <= (66'(cfg_ff.start_vel) <<< 16) + 66'(ar_ff);
         xb_ff <= (81'(cfg_ff.start_pos) <<< 33) + (81'(svt3_ff) <<< 17);
         p4_ff <= p3_ff;
         // stage 5
         aq_ff  <= (98'(ph_ff) <<< 32) + 98'(pl_ff);
         xb5_ff <= xb_ff;
         vv5_ff <= vv_ff;
         p5_ff  <= p4_ff;
         // stage 6
         x_ff   <= 100'(xb5_ff) + 100'(aq_ff);
         vv6_ff <= vv5_ff;
         p6_ff  <= p5_ff;
         // output word, saturated
         if (xs > 67'sd2147483647)       pos_ff <= 32'sh7FFFFFFF;
         else if (xs < -67'sd2147483648) pos_ff <= 32'sh80000000;
         else                            pos_ff <= xs[31:0];
         if (vs > 50'sd2147483647)       vel_ff <= 32'sh7FFFFFFF;
         else if (vs < -50'sd2147483648) vel_ff <= 32'sh80000000;
         else                            vel_ff <= vs[31:0];
         acc_ff <= p6_ff ? a : -a;
         tot_ff <= sol.total;
      end
   end

   assign rsp_valid      = vld_ff[7];
   assign rsp_pos_out    = pos_ff;
   assign rsp_vel_out    = vel_ff;
   assign rsp_accel_out  = acc_ff;
   assign rsp_total_time = tot_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !busy)
      else $error("word accepted while solver busy");
   a_write_starts: assert property (@(posedge clock) disable iff (reset)
      wr |=> busy)
      else $error("register write did not start solver");
   a_accel_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accel_out == a || rsp_accel_out == -a))
      else $error("accel word is not plus or minus the limit");
`endif

endmodule
